// ===== src/bsc_pkg.sv =====
// bsc_pkg: widths, register indexes, constants and operand structs shared by
// the barometric compensation block. No dependencies.
package bsc_pkg;

   localparam int RAW_W  = 20;
   localparam int DATA_W = 32;
   localparam int HALF_W = 16;
   localparam int WIDE_W = 64;

   // multiplier retires one digit of the second operand per cycle
   localparam int MUL_DIGIT_W = 4;
   localparam int MUL_STEPS   = WIDE_W / MUL_DIGIT_W;
   localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
   localparam int DIV_CNT_W   = $clog2(WIDE_W);

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAL_T1    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAL_T2_T3 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAL_P1    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAL_P2_P3 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAL_P4_P5 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAL_P6_P7 = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAL_P8_P9 = 3'd6;

   localparam logic OP_TEMPERATURE = 1'b0;
   localparam logic OP_PRESSURE    = 1'b1;

   localparam logic [WIDE_W-1:0] FT_OFFSET    = 64'd128000;
   localparam logic [WIDE_W-1:0] ADC_FULL     = 64'd1048576;
   localparam logic [WIDE_W-1:0] P_SCALE      = 64'd3125;
   localparam logic [WIDE_W-1:0] DIV_BIAS     = 64'd1 << 47;
   localparam logic [DATA_W-1:0] T_ROUND      = 32'd128;

   typedef struct packed {
      logic              start;
      logic [WIDE_W-1:0] a;
      logic [WIDE_W-1:0] b;
   } op_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [WIDE_W-1:0] value;
   } op_rsp_type;

   function automatic logic [WIDE_W-1:0] sx16(input logic [HALF_W-1:0] h);
      return {{(WIDE_W-HALF_W){h[HALF_W-1]}}, h};
   endfunction

   function automatic logic [WIDE_W-1:0] sx32(input logic [DATA_W-1:0] w);
      return {{(WIDE_W-DATA_W){w[DATA_W-1]}}, w};
   endfunction

endpackage

// ===== src/bsc_req_if.sv =====
// bsc_req_if: input channel of the compensation block, valid/ready with
// operation and raw sample. Depends on bsc_pkg.
interface bsc_req_if;
   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic [bsc_pkg::RAW_W-1:0]    raw_sample;

   modport source(output valid, operation, raw_sample, input ready);
   modport sink(input valid, operation, raw_sample, output ready);
endinterface

// ===== src/bsc_rsp_if.sv =====
// bsc_rsp_if: result channel of the compensation block, valid/ready with
// temperature, pressure and divide flag. Depends on bsc_pkg.
interface bsc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [bsc_pkg::DATA_W-1:0]  temperature_centi;
   logic [bsc_pkg::DATA_W-1:0]         pressure_q24_8;
   logic                               divide_by_zero;

   modport source(output valid, temperature_centi, pressure_q24_8, divide_by_zero,
                  input ready);
   modport sink(input valid, temperature_centi, pressure_q24_8, divide_by_zero,
                output ready);
endinterface

// ===== src/bsc_serial_mul.sv =====
// bsc_serial_mul: 64x64 wrapping multiplier, one 4-bit digit of b per cycle.
// Depends on bsc_pkg.
module bsc_serial_mul (
   input  logic                clock,
   input  logic                reset,
   input  bsc_pkg::op_req_type req,
   output bsc_pkg::op_rsp_type rsp
);

   logic [bsc_pkg::WIDE_W-1:0]    a_ff, a_in;
   logic [bsc_pkg::WIDE_W-1:0]    b_ff, b_in;
   logic [bsc_pkg::WIDE_W-1:0]    acc_ff, acc_in;
   logic [bsc_pkg::MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         a_in    = req.a;
         b_in    = req.b;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + bsc_pkg::WIDE_W'(a_ff * b_ff[bsc_pkg::MUL_DIGIT_W-1:0]);
         a_in   = a_ff << bsc_pkg::MUL_DIGIT_W;
         b_in   = b_ff >> bsc_pkg::MUL_DIGIT_W;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == bsc_pkg::MUL_CNT_W'(bsc_pkg::MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.busy  = busy_ff;
   assign rsp.done  = done_ff;
   assign rsp.value = acc_ff;

endmodule

// ===== src/bsc_serial_div.sv =====
// bsc_serial_div: signed 64-bit truncating divider, restoring, one quotient
// bit per cycle. Divisor must be nonzero. Depends on bsc_pkg.
module bsc_serial_div (
   input  logic                clock,
   input  logic                reset,
   input  bsc_pkg::op_req_type req,
   output bsc_pkg::op_rsp_type rsp
);

   logic [bsc_pkg::WIDE_W-1:0]    rem_ff, rem_in;
   logic [bsc_pkg::WIDE_W-1:0]    quo_ff, quo_in;
   logic [bsc_pkg::WIDE_W-1:0]    dsr_ff, dsr_in;
   logic [bsc_pkg::WIDE_W-1:0]    res_ff, res_in;
   logic                          neg_ff, neg_in;
   logic [bsc_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;

   always_comb begin
      logic [bsc_pkg::WIDE_W:0] trial;
      logic                     fits;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      res_in  = res_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[bsc_pkg::WIDE_W-1]};
      fits    = trial >= {1'b0, dsr_ff};
      if (req.start) begin
         // work on magnitudes, fix the sign at the end
         quo_in  = req.a[bsc_pkg::WIDE_W-1] ? -req.a : req.a;
         dsr_in  = req.b[bsc_pkg::WIDE_W-1] ? -req.b : req.b;
         neg_in  = req.a[bsc_pkg::WIDE_W-1] ^ req.b[bsc_pkg::WIDE_W-1];
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? bsc_pkg::WIDE_W'(trial - {1'b0, dsr_ff})
                       : trial[bsc_pkg::WIDE_W-1:0];
         quo_in = {quo_ff[bsc_pkg::WIDE_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == bsc_pkg::DIV_CNT_W'(bsc_pkg::WIDE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? -quo_in : quo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      res_ff <= res_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.busy  = busy_ff;
   assign rsp.done  = done_ff;
   assign rsp.value = res_ff;

endmodule

// ===== src/barometric_sensor_compensation_top.sv =====
// barometric_sensor_compensation_top: sequencer for temperature and pressure
// compensation. Depends on bsc_pkg, bsc_req_if, bsc_rsp_if, bsc_serial_mul,
// bsc_serial_div.
//
// Usage: the req channel takes one item (operation, raw_sample); each item
// gives one rsp item. Operation 0 is a temperature sample: it gives the
// temperature in hundredths of a degree and stores the fine temperature used
// by later pressure items. Operation 1 is a pressure sample: it gives Pa in
// Q24.8 and flags a zero divisor. Calibration words go in on the csr port
// (write enable, index, data); the user must write them only while the
// block is idle, as the block itself does not enforce it. Each product runs
// on the shared digit-serial multiplier: the request register, the start
// load, then 16 digit steps. A temperature item takes 3 products; a pressure
// item takes 10 products and a bit-serial division, or ends after its sixth
// product when the divisor is zero. One item is in work at a time; req ready
// is high only while the sequencer is idle, so the next item can be taken as
// soon as the result reaches the output register.
// The result sits in an output register; a new item is accepted while it
// waits, and a finished result stalls in the sequencer until the receiver
// takes the previous one. Reset clears all calibration words, the stored
// fine temperature and all handshake state.
module barometric_sensor_compensation_top (
   input  logic                              clock,
   input  logic                              reset,
   bsc_req_if.sink                           req_if,
   bsc_rsp_if.source                         rsp_if,
   input  logic                              csr_we,
   input  logic [bsc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bsc_pkg::DATA_W-1:0]        csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE, S_T0, S_T1, S_T2, S_T3,
      S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_P10, S_P11,
      S_OUT
   } state_type;

   localparam int W = bsc_pkg::WIDE_W;
   localparam int D = bsc_pkg::DATA_W;
   localparam int H = bsc_pkg::HALF_W;

   state_type state_ff, state_in;

   logic [H-1:0] cal_t1_ff, cal_p1_ff;
   logic [D-1:0] cal_t2_t3_ff, cal_p2_p3_ff, cal_p4_p5_ff, cal_p6_p7_ff, cal_p8_p9_ff;

   logic [bsc_pkg::RAW_W-1:0] adc_ff, adc_in;
   logic [D-1:0] ft_ff, ft_in;
   logic [W-1:0] v1_ff, v1_in, v2_ff, v2_in, m_ff, m_in, p_ff, p_in;
   logic [D-1:0] res_temp_ff, res_temp_in, res_press_ff, res_press_in;
   logic         res_dz_ff, res_dz_in;
   logic [D-1:0] out_temp_ff, out_temp_in, out_press_ff, out_press_in;
   logic         out_dz_ff, out_dz_in;
   logic         out_valid_ff, out_valid_in;

   bsc_pkg::op_req_type mul_req_ff, mul_req_in, div_req_ff, div_req_in;
   bsc_pkg::op_rsp_type mul_rsp, div_rsp;

   bsc_serial_mul u_mul (.clock(clock), .reset(reset), .req(mul_req_ff), .rsp(mul_rsp));
   bsc_serial_div u_div (.clock(clock), .reset(reset), .req(div_req_ff), .rsp(div_rsp));

   // calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_t1_ff    <= '0;
         cal_t2_t3_ff <= '0;
         cal_p1_ff    <= '0;
         cal_p2_p3_ff <= '0;
         cal_p4_p5_ff <= '0;
         cal_p6_p7_ff <= '0;
         cal_p8_p9_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            bsc_pkg::CSR_CAL_T1:    cal_t1_ff    <= csr_wdata[H-1:0];
            bsc_pkg::CSR_CAL_T2_T3: cal_t2_t3_ff <= csr_wdata;
            bsc_pkg::CSR_CAL_P1:    cal_p1_ff    <= csr_wdata[H-1:0];
            bsc_pkg::CSR_CAL_P2_P3: cal_p2_p3_ff <= csr_wdata;
            bsc_pkg::CSR_CAL_P4_P5: cal_p4_p5_ff <= csr_wdata;
            bsc_pkg::CSR_CAL_P6_P7: cal_p6_p7_ff <= csr_wdata;
            bsc_pkg::CSR_CAL_P8_P9: cal_p8_p9_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [D-1:0] a32, d32, t32, v2_32, ft32, ft5;
      logic [W-1:0] prod, x, dv, pn, sum, v2w;
      state_in     = state_ff;
      adc_in       = adc_ff;
      ft_in        = ft_ff;
      v1_in        = v1_ff;
      v2_in        = v2_ff;
      m_in         = m_ff;
      p_in         = p_ff;
      res_temp_in  = res_temp_ff;
      res_press_in = res_press_ff;
      res_dz_in    = res_dz_ff;
      out_temp_in  = out_temp_ff;
      out_press_in = out_press_ff;
      out_dz_in    = out_dz_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      mul_req_in   = '{start: 1'b0, a: mul_req_ff.a, b: mul_req_ff.b};
      div_req_in   = '{start: 1'b0, a: div_req_ff.a, b: div_req_ff.b};
      prod  = mul_rsp.value;
      a32   = {15'b0, adc_ff[19:3]} - {15'b0, cal_t1_ff, 1'b0};
      d32   = {16'b0, adc_ff[19:4]} - {16'b0, cal_t1_ff};
      t32   = D'($signed(prod[D-1:0]) >>> 12);
      v2_32 = D'($signed(prod[D-1:0]) >>> 14);
      ft32  = v1_ff[D-1:0] + v2_32;
      ft5   = ft32 + {ft32[D-3:0], 2'b0} + bsc_pkg::T_ROUND;
      x     = m_ff + (prod << 12);
      dv    = W'($signed(prod) >>> 33);
      pn    = ((bsc_pkg::ADC_FULL - {44'b0, adc_ff}) << 31) - v2_ff;
      v2w   = W'($signed(prod) >>> 19);
      sum   = p_ff + v1_ff + v2w;

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               adc_in   = req_if.raw_sample;
               state_in = (req_if.operation == bsc_pkg::OP_PRESSURE) ? S_P0 : S_T0;
            end
         end
         S_T0: begin
            mul_req_in = '{start: 1'b1, a: bsc_pkg::sx32(a32),
                           b: bsc_pkg::sx16(cal_t2_t3_ff[D-1:H])};
            state_in   = S_T1;
         end
         S_T1: if (mul_rsp.done) begin
            v1_in      = bsc_pkg::sx32(D'($signed(prod[D-1:0]) >>> 11));
            mul_req_in = '{start: 1'b1, a: bsc_pkg::sx32(d32), b: bsc_pkg::sx32(d32)};
            state_in   = S_T2;
         end
         S_T2: if (mul_rsp.done) begin
            mul_req_in = '{start: 1'b1, a: bsc_pkg::sx32(t32),
                           b: bsc_pkg::sx16(cal_t2_t3_ff[H-1:0])};
            state_in   = S_T3;
         end
         S_T3: if (mul_rsp.done) begin
            ft_in        = ft32;
            res_temp_in  = D'($signed(ft5) >>> 8);
            res_press_in = '0;
            res_dz_in    = 1'b0;
            state_in     = S_OUT;
         end
         S_P0: begin
            v1_in      = bsc_pkg::sx32(ft_ff) - bsc_pkg::FT_OFFSET;
            mul_req_in = '{start: 1'b1, a: v1_in, b: v1_in};
            state_in   = S_P1;
         end
         S_P1: if (mul_rsp.done) begin
            m_in       = prod;
            mul_req_in = '{start: 1'b1, a: prod, b: bsc_pkg::sx16(cal_p6_p7_ff[D-1:H])};
            state_in   = S_P2;
         end
         S_P2: if (mul_rsp.done) begin
            v2_in      = prod;
            mul_req_in = '{start: 1'b1, a: v1_ff, b: bsc_pkg::sx16(cal_p4_p5_ff[H-1:0])};
            state_in   = S_P3;
         end
         S_P3: if (mul_rsp.done) begin
            v2_in      = v2_ff + (prod << 17) + (bsc_pkg::sx16(cal_p4_p5_ff[D-1:H]) << 35);
            mul_req_in = '{start: 1'b1, a: m_ff, b: bsc_pkg::sx16(cal_p2_p3_ff[H-1:0])};
            state_in   = S_P4;
         end
         S_P4: if (mul_rsp.done) begin
            m_in       = W'($signed(prod) >>> 8);
            mul_req_in = '{start: 1'b1, a: v1_ff, b: bsc_pkg::sx16(cal_p2_p3_ff[D-1:H])};
            state_in   = S_P5;
         end
         S_P5: if (mul_rsp.done) begin
            mul_req_in = '{start: 1'b1, a: bsc_pkg::DIV_BIAS + x, b: {48'b0, cal_p1_ff}};
            state_in   = S_P6;
         end
         S_P6: if (mul_rsp.done) begin
            v1_in = dv;
            if (dv == '0) begin
               res_temp_in  = '0;
               res_press_in = '0;
               res_dz_in    = 1'b1;
               state_in     = S_OUT;
            end else begin
               mul_req_in = '{start: 1'b1, a: pn, b: bsc_pkg::P_SCALE};
               state_in   = S_P7;
            end
         end
         S_P7: if (mul_rsp.done) begin
            div_req_in = '{start: 1'b1, a: prod, b: v1_ff};
            state_in   = S_P8;
         end
         S_P8: if (div_rsp.done) begin
            p_in       = div_rsp.value;
            m_in       = W'($signed(div_rsp.value) >>> 13);
            mul_req_in = '{start: 1'b1, a: bsc_pkg::sx16(cal_p8_p9_ff[H-1:0]), b: m_in};
            state_in   = S_P9;
         end
         S_P9: if (mul_rsp.done) begin
            mul_req_in = '{start: 1'b1, a: prod, b: m_ff};
            state_in   = S_P10;
         end
         S_P10: if (mul_rsp.done) begin
            v1_in      = W'($signed(prod) >>> 25);
            mul_req_in = '{start: 1'b1, a: bsc_pkg::sx16(cal_p8_p9_ff[D-1:H]), b: p_ff};
            state_in   = S_P11;
         end
         S_P11: if (mul_rsp.done) begin
            res_temp_in  = '0;
            res_press_in = D'(W'($signed(sum) >>> 8)
                              + (bsc_pkg::sx16(cal_p6_p7_ff[H-1:0]) << 4));
            res_dz_in    = 1'b0;
            state_in     = S_OUT;
         end
         S_OUT: begin
            // hand over once the output register is free
            if (!out_valid_ff || rsp_if.ready) begin
               out_temp_in  = res_temp_ff;
               out_press_in = res_press_ff;
               out_dz_in    = res_dz_ff;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      adc_ff       <= adc_in;
      v1_ff        <= v1_in;
      v2_ff        <= v2_in;
      m_ff         <= m_in;
      p_ff         <= p_in;
      res_temp_ff  <= res_temp_in;
      res_press_ff <= res_press_in;
      res_dz_ff    <= res_dz_in;
      out_temp_ff  <= out_temp_in;
      out_press_ff <= out_press_in;
      out_dz_ff    <= out_dz_in;
      mul_req_ff.a <= mul_req_in.a;
      mul_req_ff.b <= mul_req_in.b;
      div_req_ff.a <= div_req_in.a;
      div_req_ff.b <= div_req_in.b;
      if (reset) begin
         state_ff         <= S_IDLE;
         ft_ff            <= '0;
         out_valid_ff     <= 1'b0;
         mul_req_ff.start <= 1'b0;
         div_req_ff.start <= 1'b0;
      end else begin
         state_ff         <= state_in;
         ft_ff            <= ft_in;
         out_valid_ff     <= out_valid_in;
         mul_req_ff.start <= mul_req_in.start;
         div_req_ff.start <= div_req_in.start;
      end
   end

   assign req_if.ready             = (state_ff == S_IDLE);
   assign rsp_if.valid             = out_valid_ff;
   assign rsp_if.temperature_centi = out_temp_ff;
   assign rsp_if.pressure_q24_8    = out_press_ff;
   assign rsp_if.divide_by_zero    = out_dz_ff;

   a_mul_not_restarted: assert property (@(posedge clock) disable iff (reset)
      mul_req_ff.start |-> !mul_rsp.busy)
      else $error("multiplier started while busy");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_rsp.busy && div_rsp.busy))
      else $error("multiplier and divider busy together");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> state_ff != S_IDLE)
      else $error("accepted item did not start the sequencer");

   a_dz_zero_pressure: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_dz_ff) |-> (out_press_ff == '0 && out_temp_ff == '0))
      else $error("divide flag with nonzero result");

   a_temp_only: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_temp_ff != '0) |-> (out_press_ff == '0 && !out_dz_ff))
      else $error("temperature item carries pressure fields");

endmodule

// ===== test/tb.sv =====
// tb: self-checking bench for barometric_sensor_compensation_top, random and
// directed samples with an in-bench compensation predictor.
// Depends on bsc_pkg, bsc_req_if, bsc_rsp_if and the block itself.
module tb;

   localparam int LIMIT_CYCLES = 3000000;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int NUM_PHASES = 8;

   typedef struct {
      logic                       operation;
      logic [bsc_pkg::RAW_W-1:0]  raw_sample;
      bit                         hold_until_drained;
   } sample_type;

   typedef struct {
      logic signed [bsc_pkg::DATA_W-1:0] temperature_centi;
      logic [bsc_pkg::DATA_W-1:0]        pressure_q24_8;
      logic                              divide_by_zero;
   } reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [bsc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [bsc_pkg::DATA_W-1:0] csr_wdata = '0;

   bsc_req_if req_ch();
   bsc_rsp_if rsp_ch();

   barometric_sensor_compensation_top dut (
      .clock(clock), .reset(reset), .req_if(req_ch), .rsp_if(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // shadow calibration and stored fine temperature
   logic [bsc_pkg::HALF_W-1:0] cal_t1 = '0, cal_p1 = '0;
   logic [bsc_pkg::DATA_W-1:0] cal_t2_t3 = '0, cal_p2_p3 = '0, cal_p4_p5 = '0;
   logic [bsc_pkg::DATA_W-1:0] cal_p6_p7 = '0, cal_p8_p9 = '0;
   logic [bsc_pkg::DATA_W-1:0] fine_t = '0;

   sample_type  pending_samples[$];
   reading_type expected_readings[$];
   int issued = 0;
   int accepted = 0;
   int errors = 0;
   int cycles = 0;
   int send_gap = 0;
   int stall_left = 0;
   bit no_idle = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 45);
   endfunction

   function automatic reading_type compensate_temperature(logic [bsc_pkg::RAW_W-1:0] adc);
      logic [bsc_pkg::DATA_W-1:0] t1, t2, t3, adc32, a, v1, d, v2, x;
      reading_type r;
      adc32 = {{(bsc_pkg::DATA_W-bsc_pkg::RAW_W){1'b0}}, adc};
      t1 = {16'b0, cal_t1};
      t2 = {{16{cal_t2_t3[31]}}, cal_t2_t3[31:16]};
      t3 = {{16{cal_t2_t3[15]}}, cal_t2_t3[15:0]};
      a = (adc32 >> 3) - (t1 << 1);
      x = a * t2;
      v1 = $signed(x) >>> 11;
      d = (adc32 >> 4) - t1;
      x = d * d;
      x = $signed(x) >>> 12;
      x = x * t3;
      v2 = $signed(x) >>> 14;
      fine_t = v1 + v2;
      x = fine_t * 32'd5 + 32'd128;
      r.temperature_centi = $signed(x) >>> 8;
      r.pressure_q24_8 = '0;
      r.divide_by_zero = 1'b0;
      return r;
   endfunction

   function automatic logic [63:0] ext16(logic [15:0] h);
      return {{48{h[15]}}, h};
   endfunction

   function automatic reading_type compensate_pressure(logic [bsc_pkg::RAW_W-1:0] adc);
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, ft, w1, w2, p, q, num, ma, mb;
      reading_type r;
      p1 = {48'b0, cal_p1};
      p2 = ext16(cal_p2_p3[31:16]); p3 = ext16(cal_p2_p3[15:0]);
      p4 = ext16(cal_p4_p5[31:16]); p5 = ext16(cal_p4_p5[15:0]);
      p6 = ext16(cal_p6_p7[31:16]); p7 = ext16(cal_p6_p7[15:0]);
      p8 = ext16(cal_p8_p9[31:16]); p9 = ext16(cal_p8_p9[15:0]);
      ft = {{32{fine_t[31]}}, fine_t};
      r.temperature_centi = '0;
      r.pressure_q24_8 = '0;
      r.divide_by_zero = 1'b0;
      w1 = ft - 64'd128000;
      w2 = w1 * w1 * p6;
      w2 = w2 + ((w1 * p5) << 17);
      w2 = w2 + (p4 << 35);
      q = w1 * w1 * p3;
      q = $signed(q) >>> 8;
      w1 = q + ((w1 * p2) << 12);
      q = ((64'd1 << 47) + w1) * p1;
      w1 = $signed(q) >>> 33;
      if (w1 == 64'd0) begin
         r.divide_by_zero = 1'b1;
         return r;
      end
      p = 64'd1048576 - {44'b0, adc};
      num = ((p << 31) - w2) * 64'd3125;
      // truncating signed divide done on magnitudes so the overflow case wraps
      ma = num[63] ? 64'd0 - num : num;
      mb = w1[63] ? 64'd0 - w1 : w1;
      p = ma / mb;
      if (num[63] != w1[63]) p = 64'd0 - p;
      q = $signed(p) >>> 13;
      w1 = p9 * q * q;
      w1 = $signed(w1) >>> 25;
      w2 = p8 * p;
      w2 = $signed(w2) >>> 19;
      q = p + w1 + w2;
      q = $signed(q) >>> 8;
      p = q + (p7 << 4);
      r.pressure_q24_8 = p[31:0];
      return r;
   endfunction

   // driver: one assignment per signal per falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.operation <= bsc_pkg::OP_TEMPERATURE;
         req_ch.raw_sample <= '0;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (issued == accepted) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_samples.size() > 0 &&
                         !(pending_samples[0].hold_until_drained &&
                           expected_readings.size() > 0)) begin
               req_ch.operation <= pending_samples[0].operation;
               req_ch.raw_sample <= pending_samples[0].raw_sample;
               req_ch.valid <= 1'b1;
               void'(pending_samples.pop_front());
               issued++;
               send_gap = pick_gap();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      reading_type want;
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end else if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            accepted <= accepted + 1;
            if (req_ch.operation == bsc_pkg::OP_TEMPERATURE)
               expected_readings.push_back(compensate_temperature(req_ch.raw_sample));
            else
               expected_readings.push_back(compensate_pressure(req_ch.raw_sample));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_readings.size() == 0) begin
               $error("result with no item outstanding");
               errors++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_ch.temperature_centi !== want.temperature_centi) begin
                  $error("temperature_centi expected %0d got %0d",
                         want.temperature_centi, rsp_ch.temperature_centi);
                  errors++;
               end
               if (rsp_ch.pressure_q24_8 !== want.pressure_q24_8) begin
                  $error("pressure_q24_8 expected %h got %h",
                         want.pressure_q24_8, rsp_ch.pressure_q24_8);
                  errors++;
               end
               if (rsp_ch.divide_by_zero !== want.divide_by_zero) begin
                  $error("divide_by_zero expected %b got %b",
                         want.divide_by_zero, rsp_ch.divide_by_zero);
                  errors++;
               end
            end
         end
      end
   end

   task automatic write_csr(logic [bsc_pkg::CSR_INDEX_W-1:0] idx,
                            logic [bsc_pkg::DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         bsc_pkg::CSR_CAL_T1:    cal_t1 = data[15:0];
         bsc_pkg::CSR_CAL_T2_T3: cal_t2_t3 = data;
         bsc_pkg::CSR_CAL_P1:    cal_p1 = data[15:0];
         bsc_pkg::CSR_CAL_P2_P3: cal_p2_p3 = data;
         bsc_pkg::CSR_CAL_P4_P5: cal_p4_p5 = data;
         bsc_pkg::CSR_CAL_P6_P7: cal_p6_p7 = data;
         bsc_pkg::CSR_CAL_P8_P9: cal_p8_p9 = data;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_calibration(logic [bsc_pkg::DATA_W-1:0] v[7]);
      write_csr(bsc_pkg::CSR_CAL_T1, v[0]);
      write_csr(bsc_pkg::CSR_CAL_T2_T3, v[1]);
      write_csr(bsc_pkg::CSR_CAL_P1, v[2]);
      write_csr(bsc_pkg::CSR_CAL_P2_P3, v[3]);
      write_csr(bsc_pkg::CSR_CAL_P4_P5, v[4]);
      write_csr(bsc_pkg::CSR_CAL_P6_P7, v[5]);
      write_csr(bsc_pkg::CSR_CAL_P8_P9, v[6]);
   endtask

   task automatic queue_sample(logic op, logic [bsc_pkg::RAW_W-1:0] raw, bit hold);
      sample_type s;
      s.operation = op;
      s.raw_sample = raw;
      s.hold_until_drained = hold;
      pending_samples.push_back(s);
   endtask

   task automatic wait_drained();
      wait (pending_samples.size() == 0 && issued == accepted &&
            expected_readings.size() == 0);
      @(negedge clock);
   endtask

   // typical part calibration, plus some mode-dependent variants
   task automatic pick_calibration(int mode, output logic [bsc_pkg::DATA_W-1:0] v[7]);
      v = '{32'd27504, {16'd26435, 16'hFC18}, 32'd36477, {16'hD643, 16'd3024},
            {16'd2855, 16'd140}, {16'hFFF9, 16'd15500}, {16'hC6F8, 16'd6000}};
      case (mode)
         1: foreach (v[i]) v[i] = $urandom();
         2: begin
            if ($urandom_range(0, 1)) v = '{32'hFFFF, 32'h7FFF7FFF, 32'hFFFF, 32'h7FFF7FFF,
                                             32'h7FFF7FFF, 32'h7FFF7FFF, 32'h7FFF7FFF};
            else v = '{32'h0, 32'h80008000, 32'h8000, 32'h80008000,
                       32'h80008000, 32'h80008000, 32'h80008000};
         end
         3: begin
            foreach (v[i]) v[i] = $urandom();
            v[2] = 32'h0;
         end
         default: begin
            v[0] = v[0] + $urandom_range(0, 2000) - 1000;
            v[2] = v[2] + $urandom_range(0, 2000) - 1000;
         end
      endcase
   endtask

   initial begin
      logic [bsc_pkg::DATA_W-1:0] cal[7];
      logic [bsc_pkg::RAW_W-1:0] raw;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero calibration: pressure before any temperature hits a zero divisor
      queue_sample(bsc_pkg::OP_PRESSURE, 20'h00000, 0);
      queue_sample(bsc_pkg::OP_TEMPERATURE, 20'h00000, 0);
      queue_sample(bsc_pkg::OP_PRESSURE, 20'hFFFFF, 0);
      wait_drained();

      pick_calibration(0, cal);
      load_calibration(cal);
      queue_sample(bsc_pkg::OP_PRESSURE, 20'd415148, 0);
      queue_sample(bsc_pkg::OP_TEMPERATURE, 20'd519888, 0);
      queue_sample(bsc_pkg::OP_PRESSURE, 20'd415148, 0);
      queue_sample(bsc_pkg::OP_PRESSURE, 20'h00000, 0);
      queue_sample(bsc_pkg::OP_PRESSURE, 20'hFFFFF, 0);
      queue_sample(bsc_pkg::OP_TEMPERATURE, 20'h00000, 0);
      queue_sample(bsc_pkg::OP_PRESSURE, 20'h55555, 0);
      queue_sample(bsc_pkg::OP_TEMPERATURE, 20'hFFFFF, 0);
      queue_sample(bsc_pkg::OP_PRESSURE, 20'hAAAAA, 1);
      queue_sample(bsc_pkg::OP_TEMPERATURE, 20'h80000, 0);
      queue_sample(bsc_pkg::OP_PRESSURE, 20'h7FFFF, 0);
      wait_drained();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         pick_calibration(ph < 4 ? ph : $urandom_range(0, 3), cal);
         load_calibration(cal);
         no_idle = (ph == 5);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            case ($urandom_range(0, 9))
               0: raw = 20'h00000;
               1: raw = 20'hFFFFF;
               2: raw = bsc_pkg::RAW_W'(32'd415148 + $urandom_range(0, 4095) - 32'd2048);
               default: raw = bsc_pkg::RAW_W'($urandom_range(0, 20'hFFFFF));
            endcase
            // mostly pressure readings, with a temperature sample one time in three
            queue_sample($urandom_range(0, 2) != 0 ? bsc_pkg::OP_PRESSURE
                                                   : bsc_pkg::OP_TEMPERATURE,
                         raw, $urandom_range(0, 99) == 0);
         end
         wait_drained();
      end

      repeat (300) @(posedge clock);
      if (errors == 0 && expected_readings.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
src/bsc_pkg.sv
src/bsc_req_if.sv
src/bsc_rsp_if.sv
src/bsc_serial_mul.sv
src/bsc_serial_div.sv
src/barometric_sensor_compensation_top.sv
test/tb.sv
